@@ hw/rtl/mcrp_pkg.sv @@
package mcrp_pkg;

    localparam int PosW   = 28;
    localparam int TopicW = 16;

    localparam logic [PosW-1:0] POS_MAX = {PosW{1'b1}};

    // Session states
    localparam logic [1:0] SS_CONNECTING  = 2'd0;
    localparam logic [1:0] SS_CONNECTED   = 2'd1;
    localparam logic [1:0] SS_SUBSCRIBING = 2'd2;
    localparam logic [1:0] SS_ACTIVE      = 2'd3;

    // Parse phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_CONNACK = 3'd1;
    localparam logic [2:0] PH_VARINT  = 3'd2;
    localparam logic [2:0] PH_TLHI    = 3'd3;
    localparam logic [2:0] PH_TLLO    = 3'd4;
    localparam logic [2:0] PH_TOPIC   = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;

    // Control packet types
    localparam logic [3:0] TYPE_CONNACK = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;
    localparam logic [3:0] TYPE_SUBACK  = 4'd9;

    // Result kinds
    localparam logic [1:0] KIND_TOPIC     = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
    localparam logic [1:0] KIND_SUBSCRIBE = 2'd2;
    localparam logic [1:0] KIND_MALFORMED = 2'd3;

    typedef struct packed {
        logic [1:0]        session_state;
        logic [PosW-1:0]   byte_position;
        logic [3:0]        packet_type;
        logic [PosW-1:0]   remaining_length;
        logic [1:0]        varint_shift;
        logic [TopicW-1:0] topic_length;
        logic [2:0]        parse_phase;
    } sess_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } res_t;

endpackage

@@ hw/rtl/mcrp_step.sv @@
module mcrp_step
    import mcrp_pkg::*;
(
    input  sess_t      st,
    input  logic       mode,
    input  logic [7:0] data_byte,
    input  logic       segment_start,
    input  logic       deliver_enable,
    output sess_t      st_next,
    output res_t       res
);

    logic [PosW-1:0]   bp_inc;
    logic [PosW-1:0]   vi_term;
    logic [PosW-1:0]   rl_acc;
    logic [TopicW-1:0] tl_full;
    logic [TopicW:0]   tl_plus2;
    logic [TopicW-1:0] tl_dec;
    logic [PosW-1:0]   rl_dec;
    logic [3:0]        type_nib;

    always_comb
    begin
        bp_inc   = (st.byte_position < POS_MAX) ? st.byte_position + 1'b1
                                                : st.byte_position;
        type_nib = data_byte[7:4];

        case (st.varint_shift)
            2'd0:    vi_term = {{(PosW-7){1'b0}}, data_byte[6:0]};
            2'd1:    vi_term = {{(PosW-14){1'b0}}, data_byte[6:0], 7'd0};
            2'd2:    vi_term = {{(PosW-21){1'b0}}, data_byte[6:0], 14'd0};
            default: vi_term = {data_byte[6:0], 21'd0};
        endcase
        rl_acc = st.remaining_length + vi_term;

        tl_full  = {st.topic_length[TopicW-1:8], data_byte};
        tl_plus2 = {1'b0, tl_full} + (TopicW+1)'(2);
        tl_dec   = st.topic_length - 1'b1;
        rl_dec   = st.remaining_length - 1'b1;

        st_next  = st;
        res      = '0;

        if (mode)
        begin
            st_next.session_state = SS_CONNECTING;
            st_next.parse_phase   = PH_IDLE;
            st_next.byte_position = '0;
        end
        else if (segment_start)
        begin
            st_next.byte_position = '0;
            st_next.packet_type   = type_nib;
            st_next.parse_phase   = PH_IDLE;
            case (st.session_state)
                SS_CONNECTING:
                begin
                    if (type_nib == TYPE_CONNACK)
                        st_next.parse_phase = PH_CONNACK;
                end
                SS_CONNECTED:
                begin
                    st_next.session_state = SS_SUBSCRIBING;
                    res.valid = 1'b1;
                    res.kind  = KIND_SUBSCRIBE;
                end
                SS_SUBSCRIBING:
                begin
                    if (type_nib == TYPE_SUBACK)
                        st_next.session_state = SS_ACTIVE;
                end
                default:
                begin
                    if (type_nib == TYPE_PUBLISH)
                    begin
                        st_next.parse_phase      = PH_VARINT;
                        st_next.remaining_length = '0;
                        st_next.varint_shift     = '0;
                        st_next.topic_length     = '0;
                    end
                end
            endcase
        end
        else
        begin
            st_next.byte_position = bp_inc;
            case (st.parse_phase)
                PH_CONNACK:
                begin
                    if (bp_inc == PosW'(3))
                    begin
                        if (data_byte == 8'd0)
                            st_next.session_state = SS_CONNECTED;
                        st_next.parse_phase = PH_IDLE;
                    end
                end
                PH_VARINT:
                begin
                    st_next.remaining_length = rl_acc;
                    if (data_byte[7])
                    begin
                        if (st.varint_shift == 2'd3)
                        begin
                            // A continuation bit on the fourth length byte makes the length invalid.
                            st_next.parse_phase = PH_IDLE;
                            res.valid = deliver_enable;
                            res.kind  = KIND_MALFORMED;
                        end
                        else
                            st_next.varint_shift = st.varint_shift + 1'b1;
                    end
                    else
                        st_next.parse_phase = PH_TLHI;
                end
                PH_TLHI:
                begin
                    st_next.topic_length = {data_byte, 8'd0};
                    st_next.parse_phase  = PH_TLLO;
                end
                PH_TLLO:
                begin
                    st_next.topic_length = tl_full;
                    if (st.remaining_length < PosW'(tl_plus2))
                    begin
                        st_next.parse_phase = PH_IDLE;
                        res.valid = deliver_enable;
                        res.kind  = KIND_MALFORMED;
                    end
                    else
                    begin
                        st_next.remaining_length = st.remaining_length - PosW'(tl_plus2);
                        if (tl_full != '0)
                            st_next.parse_phase = PH_TOPIC;
                        else if (st.remaining_length != PosW'(tl_plus2))
                            st_next.parse_phase = PH_PAYLOAD;
                        else
                            st_next.parse_phase = PH_IDLE;
                    end
                end
                PH_TOPIC:
                begin
                    st_next.topic_length = tl_dec;
                    if (tl_dec == '0)
                        st_next.parse_phase = (st.remaining_length != '0) ? PH_PAYLOAD
                                                                          : PH_IDLE;
                    res.valid    = deliver_enable;
                    res.kind     = KIND_TOPIC;
                    res.out_byte = data_byte;
                    res.last     = (tl_dec == '0) && (st.remaining_length == '0);
                end
                PH_PAYLOAD:
                begin
                    st_next.remaining_length = rl_dec;
                    if (rl_dec == '0)
                        st_next.parse_phase = PH_IDLE;
                    res.valid    = deliver_enable;
                    res.kind     = KIND_PAYLOAD;
                    res.out_byte = data_byte;
                    res.last     = (rl_dec == '0);
                end
                default:
                begin
                    st_next.parse_phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/mqtt_client_receive_parser.sv @@
// Receive-side parser for an MQTT v3.1 client session.
// Input channel (in_valid/in_ready) carries one received byte per transfer with
// its segment_start flag, or a connection-opened event when mode is 1.
// Output channel (out_valid/out_ready) carries zero or one result per input
// transfer: publish topic or payload bytes (last marks the end of a message),
// a subscribe request, or a malformed-publish flag.
// cfg_wen/cfg_wdata write deliver_enable; write it only while the block is idle.
// An accepted byte lands in the input register; the per-byte decode then runs
// from the input register and loads the result register, which drives the output.
// One byte per cycle is sustained while out_ready stays high, because the
// whole decode is a single pass between the input and result registers.
// When the receiver stalls, the result register holds and the input register
// keeps the next byte; in_ready drops only when both are full and out_ready is low.
// Reset puts the session in connecting with the parser idle, empties both
// registers and sets deliver_enable to 1.
module mqtt_client_receive_parser
    import mcrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] data_byte,
    input  logic       segment_start,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       last
);

    logic       deliver_enable_reg;
    logic       in_valid_reg;
    logic       mode_reg;
    logic [7:0] data_byte_reg;
    logic       segment_start_reg;
    sess_t      sess_reg;
    sess_t      sess_next;
    res_t       res_next;
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       step_go;

    assign step_go  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step_go;

    mcrp_step u_step (
        .st             (sess_reg),
        .mode           (mode_reg),
        .data_byte      (data_byte_reg),
        .segment_start  (segment_start_reg),
        .deliver_enable (deliver_enable_reg),
        .st_next        (sess_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deliver_enable_reg     <= 1'b1;
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            sess_reg.session_state <= SS_CONNECTING;
            sess_reg.byte_position <= '0;
            sess_reg.packet_type   <= '0;
            sess_reg.remaining_length <= '0;
            sess_reg.varint_shift  <= '0;
            sess_reg.topic_length  <= '0;
            sess_reg.parse_phase   <= PH_IDLE;
        end
        else
        begin
            if (cfg_wen)
                deliver_enable_reg <= cfg_wdata;
            if (in_ready)
                in_valid_reg <= in_valid;
            if (step_go)
                sess_reg <= sess_next;
            if (step_go)
                out_valid_reg <= res_next.valid;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg          <= mode;
            data_byte_reg     <= data_byte;
            segment_start_reg <= segment_start;
        end
        if (step_go)
        begin
            kind_reg     <= res_next.kind;
            out_byte_reg <= res_next.out_byte;
            last_reg     <= res_next.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    // A held byte must not be lost while the output side is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step_go) |=> in_valid_reg)
        else $error("input register dropped a pending byte");

    // Subscribe and malformed results carry no byte and no end mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_SUBSCRIBE || kind == KIND_MALFORMED))
            |-> (out_byte == 8'd0 && !last))
        else $error("control result carries data");

    // Only topic or payload bytes can close a message.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (kind == KIND_TOPIC || kind == KIND_PAYLOAD))
        else $error("end mark on a non-data result");

    // Publish data is only produced while the session is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && res_next.valid && res_next.kind != KIND_SUBSCRIBE)
            |-> (sess_reg.session_state == SS_ACTIVE))
        else $error("publish result outside an active session");

endmodule

@@ dv/mqtt_client_receive_parser_test.sv @@
`timescale 1ns / 1ps

module mqtt_client_receive_parser_test;
    import mcrp_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } parse_result_t;

    // Tracks the client session and parser state byte by byte and keeps the
    // results that the block still owes.
    class session_tracker;
        bit                deliver = 1'b1;
        logic [1:0]        sess = SS_CONNECTING;
        logic [PosW-1:0]   pos = '0;
        logic [3:0]        ptype = '0;
        logic [PosW-1:0]   remain = '0;
        logic [1:0]        vshift = '0;
        logic [TopicW-1:0] tlen = '0;
        logic [2:0]        phase = PH_IDLE;
        parse_result_t     due_results[$];
        int                errors = 0;

        function void push_result(logic [1:0] k, logic [7:0] d, logic l, bit gated);
            parse_result_t r;
            r.kind = k;
            r.data = d;
            r.last = l;
            if (!gated || deliver)
                due_results.push_back(r);
        endfunction

        // Returns 0 when the byte is simply ignored by the parser.
        function bit note_byte(bit m, logic [7:0] b, bit s);
            if (m)
            begin
                sess = SS_CONNECTING;
                phase = PH_IDLE;
                pos = '0;
                return 1'b1;
            end
            if (s)
            begin
                pos = '0;
                ptype = b[7:4];
                phase = PH_IDLE;
                case (sess)
                    SS_CONNECTING:
                        if (ptype == TYPE_CONNACK)
                            phase = PH_CONNACK;
                    SS_CONNECTED:
                    begin
                        sess = SS_SUBSCRIBING;
                        push_result(KIND_SUBSCRIBE, 8'h00, 1'b0, 1'b0);
                    end
                    SS_SUBSCRIBING:
                        if (ptype == TYPE_SUBACK)
                            sess = SS_ACTIVE;
                    default:
                        if (ptype == TYPE_PUBLISH)
                        begin
                            phase = PH_VARINT;
                            remain = '0;
                            vshift = '0;
                            tlen = '0;
                        end
                endcase
                return 1'b1;
            end
            if (pos != POS_MAX)
                pos++;
            if (phase == PH_IDLE)
                return 1'b0;
            case (phase)
                PH_CONNACK:
                    if (pos == 3)
                    begin
                        if (b == 8'h00)
                            sess = SS_CONNECTED;
                        phase = PH_IDLE;
                    end
                PH_VARINT:
                begin
                    remain = remain + (PosW'(b[6:0]) << (7 * vshift));
                    if (b[7])
                    begin
                        if (vshift == 2'd3)
                        begin
                            phase = PH_IDLE;
                            push_result(KIND_MALFORMED, 8'h00, 1'b0, 1'b1);
                        end
                        else
                            vshift++;
                    end
                    else
                        phase = PH_TLHI;
                end
                PH_TLHI:
                begin
                    tlen = {b, 8'h00};
                    phase = PH_TLLO;
                end
                PH_TLLO:
                begin
                    tlen = tlen | TopicW'(b);
                    if (32'(remain) < 32'(tlen) + 32'd2)
                    begin
                        phase = PH_IDLE;
                        push_result(KIND_MALFORMED, 8'h00, 1'b0, 1'b1);
                    end
                    else
                    begin
                        remain = remain - PosW'(2) - PosW'(tlen);
                        if (tlen != 0)
                            phase = PH_TOPIC;
                        else if (remain != 0)
                            phase = PH_PAYLOAD;
                        else
                            phase = PH_IDLE;
                    end
                end
                PH_TOPIC:
                begin
                    tlen--;
                    if (tlen == 0)
                        phase = (remain != 0) ? PH_PAYLOAD : PH_IDLE;
                    push_result(KIND_TOPIC, b, (tlen == 0) && (remain == 0), 1'b1);
                end
                PH_PAYLOAD:
                begin
                    remain--;
                    if (remain == 0)
                        phase = PH_IDLE;
                    push_result(KIND_PAYLOAD, b, remain == 0, 1'b1);
                end
                default:
                    phase = PH_IDLE;
            endcase
            return 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_result(logic [1:0] k, logic [7:0] d, logic l);
            parse_result_t want;
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("result with none due: kind=%0d byte=%02h last=%0d",
                                          k, d, l));
                return;
            end
            want = due_results.pop_front();
            if (k !== want.kind || d !== want.data || l !== want.last)
                report_mismatch($sformatf("kind=%0d/%0d byte=%02h/%02h last=%0d/%0d (got/due)",
                                          k, want.kind, d, want.data, l, want.last));
        endtask

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_wen;
    logic       cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic       mode;
    logic [7:0] data_byte;
    logic       segment_start;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    session_tracker sb = new();
    bit          quiet = 1'b0;
    bit          hold_request = 1'b0;
    int          items_done = 0;
    int unsigned cycle_count = 0;

    mqtt_client_receive_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .data_byte    (data_byte),
        .segment_start(segment_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_byte     (out_byte),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(kind, out_byte, last);
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("mqtt_client_receive_parser: mismatch");
        $finish;
    end

    initial
    begin : receiver
        int gap;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                gap = quiet ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Valid stays high between back-to-back items, so it is only lowered
    // when a gap precedes the next transfer.
    task automatic send_item(bit m, logic [7:0] b, bit s);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        data_byte     <= b;
        segment_start <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        void'(sb.note_byte(m, b, s));
        items_done++;
    endtask

    task automatic send_segment(input logic [7:0] seg[$]);
        foreach (seg[i])
            send_item(1'b0, seg[i], i == 0);
    endtask

    task automatic set_delivery(bit enable);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= enable;
        @(posedge clk);
        cfg_wen <= 1'b0;
        sb.deliver = enable;
    endtask

    // Builds one PUBLISH segment. The remaining length is the honest value
    // plus len_delta; pad adds zero varint groups, up to five in total.
    task automatic send_publish(int topic_len, int pay_len, int len_delta, int pad, int trail);
        logic [7:0]      seg[$];
        logic [6:0]      groups[$];
        logic [PosW-1:0] rem;
        longint          rl;
        int              topic_sent;
        seg.push_back({TYPE_PUBLISH, 4'($urandom)});
        rl = 2 + topic_len + pay_len + len_delta;
        if (rl < 0)
            rl = 0;
        if (rl > POS_MAX)
            rl = POS_MAX;
        rem = rl[PosW-1:0];
        do
        begin
            groups.push_back(rem[6:0]);
            rem = rem >> 7;
        end
        while (rem != 0);
        for (int i = 0; i < pad && groups.size() < 5; i++)
            groups.push_back(7'h00);
        foreach (groups[i])
            seg.push_back({(i != groups.size() - 1) ? 1'b1 : 1'b0, groups[i]});
        seg.push_back(8'(topic_len >> 8));
        seg.push_back(8'(topic_len));
        topic_sent = (topic_len > 16) ? 3 : topic_len;
        repeat (topic_sent) seg.push_back(8'($urandom));
        repeat (pay_len) seg.push_back(8'($urandom));
        repeat (trail) seg.push_back(8'($urandom));
        send_segment(seg);
    endtask

    task automatic random_publish();
        int         pick;
        int         tl;
        int         pl;
        logic [7:0] seg[$];
        logic [7:0] hdr;
        pick = $urandom_range(0, 99);
        tl = $urandom_range(0, 6);
        pl = $urandom_range(0, 10);
        if (pick < 70)
            send_publish(tl, pl, 0, ($urandom_range(0, 3) == 0) ? 1 : 0, $urandom_range(0, 1));
        else if (pick < 78)
            send_publish(tl, pl, -pl - int'($urandom_range(1, 3)), 0, 0);
        else if (pick < 86)
            send_publish(tl, pl, int'($urandom_range(1, 5)), 0, 0);
        else if (pick < 91)
            send_publish(tl, pl, 0, 4, 0);
        else if (pick < 95)
            send_publish(int'($urandom_range(0, 65535)), 2, 0, 0, 0);
        else
        begin
            hdr = 8'($urandom);
            if (hdr[7:4] == TYPE_PUBLISH)
                hdr[7:4] = TYPE_SUBACK;
            seg.push_back(hdr);
            repeat ($urandom_range(0, 3)) seg.push_back(8'($urandom));
            send_segment(seg);
        end
    endtask

    // One session from connection opened to a run of publishes, with the
    // occasional refused or truncated handshake segment.
    task automatic random_session();
        logic [7:0] seg[$];
        logic [7:0] hdr;
        bit         accepted;
        int         pick;
        quiet = ($urandom_range(0, 4) == 0);
        send_item(1'b1, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 2)) send_item(1'b0, 8'($urandom), 1'b0);
        accepted = 1'b0;
        while (!accepted)
        begin
            pick = $urandom_range(0, 9);
            hdr = {TYPE_CONNACK, 4'($urandom)};
            if (pick == 0)
                seg = {hdr, 8'h02};
            else if (pick == 1)
                seg = {hdr, 8'h02, 8'h00, 8'($urandom_range(1, 255))};
            else if (pick == 2)
            begin
                hdr = 8'($urandom);
                if (hdr[7:4] == TYPE_CONNACK)
                    hdr[7:4] = TYPE_SUBACK;
                seg = {hdr, 8'h02, 8'h00, 8'h00};
            end
            else
            begin
                seg = {hdr, 8'h02, 8'h00, 8'h00, 8'($urandom)};
                accepted = 1'b1;
            end
            send_segment(seg);
        end
        seg = {8'($urandom)};
        repeat ($urandom_range(0, 2)) seg.push_back(8'($urandom));
        send_segment(seg);
        if ($urandom_range(0, 4) == 0)
        begin
            hdr = 8'($urandom);
            if (hdr[7:4] == TYPE_SUBACK)
                hdr[7:4] = TYPE_CONNACK;
            send_item(1'b0, hdr, 1'b1);
        end
        hdr = {TYPE_SUBACK, 4'($urandom)};
        seg = {hdr};
        seg.push_back(8'($urandom));
        send_segment(seg);
        repeat ($urandom_range(2, 8)) random_publish();
    endtask

    task automatic noise_burst();
        quiet = 1'b0;
        repeat ($urandom_range(4, 12))
            send_item($urandom_range(0, 7) == 0, 8'($urandom), 1'($urandom));
    endtask

    initial
    begin : stimulus
        logic [7:0] seg[$];
        int         session_count;
        rst_n         <= 1'b0;
        cfg_wen       <= 1'b0;
        cfg_wdata     <= 1'b0;
        in_valid      <= 1'b0;
        mode          <= 1'b0;
        data_byte     <= 8'h00;
        segment_start <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b0, 8'hA5, 1'b0);
        // A CONNACK cut short leaves the session connecting.
        seg = {8'h20, 8'h02};
        send_segment(seg);
        seg = {8'h2F, 8'h02, 8'h00, 8'h00};
        send_segment(seg);
        send_item(1'b0, 8'hFF, 1'b1);
        send_item(1'b0, 8'h9F, 1'b1);
        send_publish(1, 1, 0, 0, 0);
        send_publish(0, 0, 0, 0, 1);
        send_publish(0, 0, 0, 4, 0);
        send_publish(1, 0, -1, 0, 0);
        send_publish(16'hFFFF, 0, 32'h0FFF_FFFF, 0, 0);

        items_done = 0;
        session_count = 0;
        hold_request = 1'b1;
        while (items_done < RANDOM_ITEMS)
        begin
            if (session_count % 5 == 4)
                set_delivery(!sb.deliver);
            if ($urandom_range(0, 9) == 0)
                noise_burst();
            else
                random_session();
            session_count++;
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("mqtt_client_receive_parser: match");
        else
            $display("mqtt_client_receive_parser: mismatch");
        $finish;
    end

endmodule

@@ mqtt_client_receive_parser.f @@
hw/rtl/mcrp_pkg.sv
hw/rtl/mcrp_step.sv
hw/rtl/mqtt_client_receive_parser.sv
dv/mqtt_client_receive_parser_test.sv
